// ===== sv/utf8_stream_validator_unit_macros.svh =====
// Assertion macros used by the UTF-8 stream validator top level.
`ifndef UTF8_STREAM_VALIDATOR_UNIT_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define U8SV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8sv: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define U8SV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8sv: next-cycle check failed");

`endif

// ===== sv/u8sv_pkg.sv =====
// Types, byte codes and byte classifier for the UTF-8 stream validator.
package u8sv_pkg;

  localparam logic [7:0] ContMask  = 8'b1100_0000;
  localparam logic [7:0] ContCode  = 8'b1000_0000;
  localparam logic [7:0] AsciiBit  = 8'b1000_0000;
  localparam logic [7:0] Lead2Mask = 8'b1110_0000;
  localparam logic [7:0] Lead2Code = 8'b1100_0000;
  localparam logic [7:0] Lead3Mask = 8'b1111_0000;
  localparam logic [7:0] Lead3Code = 8'b1110_0000;
  localparam logic [7:0] Lead4Mask = 8'b1111_1000;
  localparam logic [7:0] Lead4Code = 8'b1111_0000;

  typedef enum logic [2:0] {
    BC_ZERO,
    BC_ASCII,
    BC_CONT,
    BC_LEAD2,
    BC_LEAD3,
    BC_LEAD4,
    BC_BAD
  } u8sv_byte_class_e;

  // Input item as it sits in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       no_byte;
    logic       last;
  } u8sv_item_t;

  // Verdict handed to the result register.
  typedef struct packed {
    logic push;
    logic is_valid;
  } u8sv_result_t;

  // Running per-string state.
  typedef struct packed {
    logic [1:0] pending;
    logic       failed;
  } u8sv_state_t;

  function automatic u8sv_byte_class_e u8sv_classify(input logic [7:0] b);
    u8sv_byte_class_e cls;
    if (b == 8'h00) begin
      cls = BC_ZERO;
    end else if ((b & AsciiBit) == 8'h00) begin
      cls = BC_ASCII;
    end else if ((b & ContMask) == ContCode) begin
      cls = BC_CONT;
    end else if ((b & Lead2Mask) == Lead2Code) begin
      cls = BC_LEAD2;
    end else if ((b & Lead3Mask) == Lead3Code) begin
      cls = BC_LEAD3;
    end else if ((b & Lead4Mask) == Lead4Code) begin
      cls = BC_LEAD4;
    end else begin
      cls = BC_BAD;
    end
    return cls;
  endfunction

endpackage

// ===== sv/u8sv_in_stage.sv =====
// Input register stage of the UTF-8 stream validator.
module u8sv_in_stage
  import u8sv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       no_byte_i,
  input  logic       last_i,
  input  logic       consume_i,
  output logic       vld_o,
  output u8sv_item_t item_o
);

  logic       vld_q;
  logic       vld_d;
  u8sv_item_t item_q;
  logic       take;

  // Stall only while a held item cannot leave this cycle.
  assign in_stall_o = vld_q & ~consume_i;
  assign take       = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (consume_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{data_byte: data_byte_i, no_byte: no_byte_i, last: last_i};
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ===== sv/u8sv_check.sv =====
// Per-string rule check: byte classification, owed-continuation count, verdict.
module u8sv_check
  import u8sv_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         vld_i,
  input  u8sv_item_t   item_i,
  input  logic         out_free_i,
  output logic         consume_o,
  output u8sv_result_t result_o,
  output u8sv_state_t  state_o
);

  u8sv_state_t      state_q;
  u8sv_state_t      state_d;
  u8sv_state_t      step;
  u8sv_byte_class_e cls;

  assign cls = u8sv_classify(item_i.data_byte);

  // Items without a verdict always drain; a verdict needs room downstream.
  assign consume_o = vld_i & (~item_i.last | out_free_i);

  always_comb begin
    step = state_q;
    if (!item_i.no_byte && !state_q.failed) begin
      if (state_q.pending != 2'd0) begin
        if (cls == BC_CONT) begin
          step.pending = state_q.pending - 2'd1;
        end else begin
          step.failed  = 1'b1;
          step.pending = 2'd0;
        end
      end else begin
        case (cls)
          BC_ASCII: step.pending = 2'd0;
          BC_LEAD2: step.pending = 2'd1;
          BC_LEAD3: step.pending = 2'd2;
          BC_LEAD4: step.pending = 2'd3;
          default:  step.failed  = 1'b1;
        endcase
      end
    end
  end

  always_comb begin
    state_d = state_q;
    if (consume_o) begin
      state_d = item_i.last ? '0 : step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign result_o.push     = consume_o & item_i.last;
  assign result_o.is_valid = ~step.failed & (step.pending == 2'd0);
  assign state_o           = state_q;

endmodule

// ===== sv/u8sv_out_stage.sv =====
// Result register of the UTF-8 stream validator.
module u8sv_out_stage
  import u8sv_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  u8sv_result_t result_i,
  output logic         out_free_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic         is_valid_o
);

  logic vld_q;
  logic vld_d;
  logic is_valid_q;

  assign out_free_o = ~vld_q | ~out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (result_i.push) begin
      vld_d = 1'b1;
    end else if (vld_q && !out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.push) begin
      is_valid_q <= result_i.is_valid;
    end
  end

  assign out_valid_o = vld_q;
  assign is_valid_o  = is_valid_q;

endmodule

// ===== sv/utf8_stream_validator_unit.sv =====
// UTF-8 stream validator: per-string verdict under simplified UTF-8 rules.
//
// Feed one byte per input transfer; the transfer with last_i high closes the
// string and yields exactly one output transfer carrying is_valid_o. A zero
// byte, a stray continuation byte, a byte 11111xxx, a missing continuation
// or a string that ends while continuations are still owed makes the verdict
// 0; overlong forms and surrogates are not checked. A transfer with
// no_byte_i high carries no byte: with last_i low it changes nothing and
// returns nothing, with last_i high it just closes the string (an empty
// string reads as valid). Throughput is one transfer per clock while
// in_stall_o is low. An accepted closing transfer sits in the input
// register, where the byte is classified and the two-bit owed-continuation
// count and fail flag advance; it leaves once the result register has room,
// and the verdict enters the result register and raises out_valid_o. The
// result register frees the input side, so a new byte is taken while a
// verdict still waits; in_stall_o rises only when the input register
// holds a closing item and the result register is full and stalled.
// No clearing pass after reset.
`include "utf8_stream_validator_unit_macros.svh"

module utf8_stream_validator_unit
  import u8sv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       no_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_valid_o
);

  logic         in_vld;
  u8sv_item_t   in_item;
  logic         consume;
  logic         out_free;
  u8sv_result_t result;
  u8sv_state_t  state;

  // Hold the incoming transfer.
  u8sv_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .no_byte_i   (no_byte_i),
    .last_i      (last_i),
    .consume_i   (consume),
    .vld_o       (in_vld),
    .item_o      (in_item)
  );

  // Advance the string state and form the verdict.
  u8sv_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (in_vld),
    .item_i     (in_item),
    .out_free_i (out_free),
    .consume_o  (consume),
    .result_o   (result),
    .state_o    (state)
  );

  // Park the verdict until the consumer takes it.
  u8sv_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_valid_o  (is_valid_o)
  );

  // A verdict only leaves the check stage for a closing item with room ahead.
  `U8SV_ASSERT_IMPL(a_push_on_last, clk_i, rst_ni, result.push, in_vld && in_item.last && out_free)
  // Input stalls only while the input register is occupied.
  `U8SV_ASSERT_IMPL(a_stall_when_full, clk_i, rst_ni, in_stall_o, in_vld)
  // Closing a string returns the string state to its idle value.
  `U8SV_ASSERT_NEXT(a_state_clears, clk_i, rst_ni, result.push, state == '0)
  // A pushed verdict appears at the output on the next cycle.
  `U8SV_ASSERT_NEXT(a_push_shows, clk_i, rst_ni, result.push, out_valid_o)

endmodule

// ===== tb/sv/tb_utf8_stream_validator_unit.sv =====
// Self-checking testbench for the UTF-8 stream validator: directed strings, then random ones.
module tb_utf8_stream_validator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Byte tags used to build well-formed characters.
  localparam logic [7:0] ContTag  = 8'b1000_0000;
  localparam logic [7:0] Lead2Tag = 8'b1100_0000;
  localparam logic [7:0] Lead3Tag = 8'b1110_0000;
  localparam logic [7:0] Lead4Tag = 8'b1111_0000;

  localparam int NumDirected  = 23;
  localparam int RandomItems  = 1250;
  localparam int IdlePercent  = 32;
  localparam int DrainCycles  = 4000;

  // Source of the expected verdict for a closing transfer.
  typedef enum logic [1:0] {
    WANT_MODEL,
    WANT_VALID,
    WANT_INVALID
  } want_e;

  typedef struct packed {
    logic [7:0] data;
    logic       no_byte;
    logic       last;
    want_e      want;
  } xfer_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       no_byte_i;
  logic       last_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       is_valid_o;

  // Expected verdict of the transfer now on the input port.
  want_e drv_want;
  // Suppress idling on both sides during one stretch of the random part.
  bit    quiet_phase;

  // Predictor state: continuation bytes still owed, and the sticky fail flag.
  logic [1:0] owed_cont;
  logic       str_failed;

  // Verdicts predicted but not yet seen at the output.
  bit    verdict_q[$];
  xfer_t pend_q[$];
  xfer_t dir_rows[NumDirected];

  int errors;
  int bytes_taken;
  int verdicts_valid;
  int verdicts_invalid;

  utf8_stream_validator_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .data_byte_i(data_byte_i),
    .no_byte_i  (no_byte_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .is_valid_o (is_valid_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: the slowest legal run ends far earlier than this.
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Advance the predicted string state by one transfer. Returns 1 when the
  // transfer closes the string; ok then holds the verdict.
  function automatic bit utf8_step(input logic [7:0] b, input logic nb, input logic lst,
                                   output bit ok);
    if (!nb && !str_failed) begin
      if (owed_cont != 2'd0) begin
        // A continuation is owed: anything but 10xxxxxx breaks the string.
        if ((b & Lead2Tag) == ContTag) begin
          owed_cont = owed_cont - 2'd1;
        end else begin
          str_failed = 1'b1;
          owed_cont  = 2'd0;
        end
      end else begin
        casez (b)
          8'b0000_0000: str_failed = 1'b1;
          8'b0???_????: begin
            // plain ASCII stands alone
          end
          8'b110?_????: owed_cont = 2'd1;
          8'b1110_????: owed_cont = 2'd2;
          8'b1111_0???: owed_cont = 2'd3;
          default:      str_failed = 1'b1;
        endcase
      end
    end
    ok = !str_failed && (owed_cont == 2'd0);
    if (lst) begin
      owed_cont  = 2'd0;
      str_failed = 1'b0;
    end
    return lst;
  endfunction

  // Input side: predict on every accepted transfer. Output side: compare
  // every accepted verdict with the oldest prediction.
  always @(posedge clk_i) begin
    bit ok;
    bit got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (!no_byte_i) bytes_taken++;
        if (utf8_step(data_byte_i, no_byte_i, last_i, ok)) begin
          case (drv_want)
            WANT_VALID:   verdict_q.push_back(1'b1);
            WANT_INVALID: verdict_q.push_back(1'b0);
            default:      verdict_q.push_back(ok);
          endcase
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict %0b with none expected", is_valid_o));
        end else begin
          got = verdict_q.pop_front();
          if (is_valid_o !== got) begin
            report_mismatch($sformatf("is_valid got %b, expected %0b", is_valid_o, got));
          end
        end
        if (is_valid_o === 1'b1) verdicts_valid++;
        else verdicts_invalid++;
      end
    end
  end

  // Receiver: stall at random except in the quiet stretch.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= !quiet_phase && ($urandom_range(99) < IdlePercent);
    end
  end

  // Present one transfer and hold it until accepted. Idle first at random.
  // Returns right after the accepting edge.
  task automatic send_xfer(input xfer_t x);
    bit idle;
    idle = 1'b1;
    while (idle) begin
      @(negedge clk_i);
      idle = !quiet_phase && ($urandom_range(99) < IdlePercent);
      if (idle) begin
        in_valid_i  <= 1'b0;
        data_byte_i <= 8'($urandom_range(255));
      end
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= x.data;
    no_byte_i   <= x.no_byte;
    last_i      <= x.last;
    drv_want    <= x.want;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  // Drop valid and hold off until every predicted verdict has come back.
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
  endtask

  // Queue one random string. Most strings are well formed with random
  // payload bits; some get one defect, some are raw noise.
  task automatic build_random_string();
    logic [7:0] bytes_q[$];
    int         n_chars;
    int         pick;
    int         pos;
    bit         close_apart;
    xfer_t      row;
    if ($urandom_range(99) < 10) begin
      n_chars = $urandom_range(6, 1);
      repeat (n_chars) bytes_q.push_back(8'($urandom_range(255)));
    end else begin
      n_chars = $urandom_range(6, 0);
      repeat (n_chars) begin
        pick = $urandom_range(3);
        case (pick)
          0:       bytes_q.push_back(8'($urandom_range(127, 1)));
          1:       bytes_q.push_back(Lead2Tag | 8'($urandom_range(31)));
          2:       bytes_q.push_back(Lead3Tag | 8'($urandom_range(15)));
          default: bytes_q.push_back(Lead4Tag | 8'($urandom_range(7)));
        endcase
        repeat (pick) bytes_q.push_back(ContTag | 8'($urandom_range(63)));
      end
      // Break the string in one place: wrong byte, zero byte, stray
      // continuation, or a cut-off tail.
      if (bytes_q.size() != 0 && $urandom_range(99) < 25) begin
        pos = $urandom_range(bytes_q.size() - 1);
        case ($urandom_range(3))
          0:       bytes_q[pos] = 8'($urandom_range(255));
          1:       bytes_q.insert(pos, 8'h00);
          2:       bytes_q.insert(pos, ContTag | 8'($urandom_range(63)));
          default: void'(bytes_q.pop_back());
        endcase
      end
    end
    close_apart = (bytes_q.size() == 0) || ($urandom_range(3) == 0);
    foreach (bytes_q[i]) begin
      if ($urandom_range(99) < 5) begin
        // empty transfer inside the string: must change nothing
        row.data    = 8'($urandom_range(255));
        row.no_byte = 1'b1;
        row.last    = 1'b0;
        row.want    = WANT_MODEL;
        pend_q.push_back(row);
      end
      row.data    = bytes_q[i];
      row.no_byte = 1'b0;
      row.last    = !close_apart && (i == bytes_q.size() - 1);
      row.want    = WANT_MODEL;
      pend_q.push_back(row);
    end
    if (close_apart) begin
      row.data    = 8'($urandom_range(255));
      row.no_byte = 1'b1;
      row.last    = 1'b1;
      row.want    = WANT_MODEL;
      pend_q.push_back(row);
    end
  endtask

  initial begin
    int    n_rand;
    bit    paused_mid;
    xfer_t row;

    // Directed strings: verdicts typed in where they are obvious.
    dir_rows = '{
      '{8'h00, 1'b1, 1'b1, WANT_VALID},    // empty string
      '{8'h41, 1'b0, 1'b1, WANT_VALID},
      '{8'h00, 1'b0, 1'b1, WANT_INVALID},  // zero byte
      '{8'h7F, 1'b0, 1'b1, WANT_VALID},
      '{8'hFF, 1'b0, 1'b1, WANT_INVALID},  // no lead pattern fits
      '{8'h80, 1'b0, 1'b1, WANT_INVALID},  // stray continuation
      '{8'hC3, 1'b0, 1'b0, WANT_MODEL},
      '{8'hA9, 1'b0, 1'b1, WANT_MODEL},
      '{8'hE2, 1'b0, 1'b0, WANT_MODEL},
      '{8'h82, 1'b0, 1'b0, WANT_MODEL},
      '{8'hAC, 1'b0, 1'b1, WANT_MODEL},
      '{8'hF7, 1'b0, 1'b0, WANT_MODEL},
      '{8'hBF, 1'b0, 1'b0, WANT_MODEL},
      '{8'h80, 1'b0, 1'b0, WANT_MODEL},
      '{8'hBF, 1'b0, 1'b1, WANT_MODEL},
      '{8'hE2, 1'b0, 1'b1, WANT_INVALID},  // truncated sequence
      '{8'hC3, 1'b0, 1'b0, WANT_MODEL},
      '{8'hFF, 1'b1, 1'b0, WANT_MODEL},    // no byte, not last
      '{8'h41, 1'b0, 1'b0, WANT_MODEL},    // bad continuation
      '{8'h80, 1'b0, 1'b0, WANT_MODEL},    // ignored after failure
      '{8'h00, 1'b1, 1'b1, WANT_INVALID},
      '{8'hF8, 1'b0, 1'b1, WANT_INVALID},
      '{8'h01, 1'b0, 1'b1, WANT_VALID}
    };

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    no_byte_i   = 1'b0;
    last_i      = 1'b0;
    out_stall_i = 1'b0;
    drv_want    = WANT_MODEL;
    quiet_phase = 1'b0;
    owed_cont   = 2'd0;
    str_failed  = 1'b0;
    errors      = 0;
    paused_mid  = 1'b0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_xfer(dir_rows[i]);
    hold_until_drained();

    n_rand = 0;
    while (n_rand < RandomItems) begin
      quiet_phase = (n_rand >= 500) && (n_rand < 760);
      build_random_string();
      while (pend_q.size() != 0) begin
        row = pend_q.pop_front();
        send_xfer(row);
        if (!(row.no_byte && !row.last)) n_rand++;
      end
      // Pause the sender once more mid-run until the output side catches up.
      if (!paused_mid && n_rand >= 900) begin
        paused_mid = 1'b1;
        hold_until_drained();
      end
    end
    quiet_phase = 1'b0;

    // Drain: wait for outstanding verdicts, then idle on to catch strays.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int k = 0; k < DrainCycles && verdict_q.size() != 0; k++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (verdict_q.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
    end

    $display("Covered %0d bytes in %0d strings (%0d valid, %0d invalid), %0d mismatches.",
             bytes_taken, verdicts_valid + verdicts_invalid, verdicts_valid,
             verdicts_invalid, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
